// File: rtl/assert_macros.svh
// Assertion helpers shared by the codec modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define B64_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define B64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/b64sc_pkg.sv
`default_nettype none

package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // group queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one group of results: bytes[0] leaves first, last_idx is count - 1
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
        logic            bad;
    } t_job;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26)      c = 8'h41 + {2'b00, s};
        else if (s < 6'd52) c = 8'h47 + {2'b00, s};
        else if (s < 6'd62) c = {2'b00, s} - 8'd4;
        else if (s == 6'd62) c = 8'h2B;
        else                c = 8'h2F;
        return c;
    endfunction

    // character to {invalid, sextet}
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'h00;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h47;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'd4;
            r = {1'b0, t[5:0]};
        end else if (c == 8'h2B) begin
            r = 7'd62;
        end else if (c == 8'h2F) begin
            r = 7'd63;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64sc_ifs.sv
`default_nettype none

// input channel: one byte or character per request
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

// result channel
interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_message;
    logic       bad_symbol;
    modport source (output valid, out_byte, last_of_message, bad_symbol, input ready);
    modport sink   (input valid, out_byte, last_of_message, bad_symbol, output ready);
endinterface

// direction register write channel
interface b64sc_cfg_if;
    logic valid;
    logic ready;
    logic direction;
    modport source (output valid, direction, input ready);
    modport sink   (input valid, direction, output ready);
endinterface

`default_nettype wire

// File: rtl/b64sc_front.sv
`default_nettype none
`include "assert_macros.svh"

module b64sc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64sc_in_if.sink         i_in,
    b64sc_cfg_if.sink        i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output b64sc_pkg::t_job  o_job
);
    import b64sc_pkg::*;

    logic        r_dir;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_fill, n_fill;
    logic        r_pad, n_pad;
    logic        r_err, n_err;

    logic        accept;
    logic        eom;
    logic [7:0]  din;
    logic [23:0] acc_bits;
    logic [1:0]  acc_fill;
    logic [23:0] enc_v;
    logic [2:0]  enc_real;
    logic [2:0]  n_res;
    logic [6:0]  sx;
    logic [3:0][7:0] chars;
    logic [3:0][7:0] dec_bytes;

    assign din         = i_in.data_byte;
    assign eom         = i_in.end_of_message;
    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_q_full;

    // classify the request and work out the next group state
    always_comb begin
        n_bits    = r_bits;
        n_fill    = r_fill;
        n_pad     = r_pad;
        n_err     = r_err;
        acc_bits  = 24'h0;
        acc_fill  = 2'd0;
        enc_v     = 24'h0;
        enc_real  = 3'd0;
        n_res     = 3'd0;
        sx        = 7'h0;
        dec_bytes = '0;
        if (!r_dir) begin
            acc_bits = {r_bits[15:0], din};
            acc_fill = r_fill + 2'd1;
            n_bits   = acc_bits;
            n_fill   = acc_fill;
            if (acc_fill == 2'd3) begin
                enc_v    = acc_bits;
                enc_real = 3'd4;
                n_res    = 3'd4;
                n_bits   = 24'h0;
                n_fill   = 2'd0;
            end else if (eom) begin
                if (acc_fill == 2'd1) begin
                    enc_v    = {acc_bits[7:0], 16'h0};
                    enc_real = 3'd2;
                    n_res    = 3'd4;
                end else if (acc_fill == 2'd2) begin
                    enc_v    = {acc_bits[15:0], 8'h0};
                    enc_real = 3'd3;
                    n_res    = 3'd4;
                end
            end
        end else begin
            if (!r_pad) begin
                if (din == PAD_CHAR) begin
                    n_pad = 1'b1;
                end else begin
                    sx     = dec_sextet(din);
                    n_err  = r_err | sx[6];
                    n_bits = {r_bits[17:0], sx[6] ? 6'h00 : sx[5:0]};
                    n_fill = r_fill + 2'd1;
                    if (n_fill == 2'd0) begin
                        dec_bytes[0] = n_bits[23:16];
                        dec_bytes[1] = n_bits[15:8];
                        dec_bytes[2] = n_bits[7:0];
                        n_res        = 3'd3;
                        n_bits       = 24'h0;
                    end
                end
            end
            // flush of a short group
            if (eom && n_res == 3'd0) begin
                if (n_fill == 2'd2) begin
                    dec_bytes[0] = n_bits[11:4];
                    n_res        = 3'd1;
                end else if (n_fill == 2'd3) begin
                    dec_bytes[0] = n_bits[17:10];
                    dec_bytes[1] = n_bits[9:2];
                    n_res        = 3'd2;
                end
            end
        end
        if (eom) begin
            n_bits = 24'h0;
            n_fill = 2'd0;
            n_pad  = 1'b0;
            n_err  = 1'b0;
        end
    end

    // alphabet characters, padding from enc_real onward
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            chars[k] = (3'(k) < enc_real) ? enc_char(enc_v[23 - 6 * k -: 6]) : PAD_CHAR;
        end
    end

    assign o_push         = accept && (n_res != 3'd0);
    assign o_job.bytes    = r_dir ? dec_bytes : chars;
    assign o_job.last_idx = 2'(n_res - 3'd1);
    assign o_job.last     = eom;
    assign o_job.bad      = r_dir ? (r_err | (!r_pad && din != PAD_CHAR && sx[6])) : 1'b0;

    // group state and direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_bits <= 24'h0;
            r_fill <= 2'd0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_cfg.valid) begin
            r_dir  <= i_cfg.direction;
            r_bits <= 24'h0;
            r_fill <= 2'd0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (accept) begin
            r_bits <= n_bits;
            r_fill <= n_fill;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

    `B64_ASSERT(a_enc_never_bad, i_clk, i_rst_n, (o_push && !r_dir) |-> !o_job.bad, "bad symbol flagged while encoding")

endmodule

`default_nettype wire

// File: rtl/b64sc_queue.sv
`default_nettype none
`include "assert_macros.svh"

module b64sc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64sc_pkg::t_job  i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output b64sc_pkg::t_job  o_job
);
    import b64sc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    `B64_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= Q_CNT_W'(Q_DEPTH), "queue fill above depth")
    `B64_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> o_valid, "pop from empty queue")
    `B64_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> (!o_full || i_pop), "push into full queue")

endmodule

`default_nettype wire

// File: rtl/b64sc_back.sv
`default_nettype none

module b64sc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  b64sc_pkg::t_job  i_job,
    output logic             o_pop,
    b64sc_out_if.source      o_out
);
    import b64sc_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;
    logic       fire;
    logic       at_end;

    assign fire   = r_busy && o_out.ready;
    assign at_end = (r_idx == r_job.last_idx);
    assign o_pop  = i_q_valid && (!r_busy || (fire && at_end));

    // result drive from the held group
    assign o_out.valid           = r_busy;
    assign o_out.out_byte        = r_job.bytes[r_idx];
    assign o_out.last_of_message = r_job.last && at_end;
    assign o_out.bad_symbol      = r_job.bad;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // walk through the group one result a cycle while the result side is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (fire && at_end) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/base64_stream_codec_unit.sv
// Streaming base64 codec, standard alphabet with '=' padding. The direction register
// picks encoding (0) or decoding (1); a write to it also clears any part-built group,
// and is to be made only while the block is idle. The front end takes one request per
// cycle whenever the two-entry group queue has room and turns each request that
// completes a group into a group of one to four results; the back end then drives one
// result per cycle, while the result side is ready, from the group it holds; each group
// passes through the group queue and the back end's group register on its way out.
// When encoding, sustained rate is set by that single output, as every three bytes give
// four characters, with the queue absorbing short stalls on either side.
`default_nettype none

module base64_stream_codec_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64sc_in_if.sink     i_in,
    b64sc_cfg_if.sink    i_cfg,
    b64sc_out_if.source  o_out
);
    import b64sc_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job q_in_job;
    t_job q_out_job;

    b64sc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in_job)
    );

    b64sc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    b64sc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_out_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// File: tb/b64sc_stream_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and direction channels of the codec, keeps its
// own copy of the codec state and compares every accepted result in order.
module b64sc_stream_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    b64sc_in_if   i_in_mon,
    b64sc_cfg_if  i_cfg_mon,
    b64sc_out_if  i_out_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_results_seen
);
    import b64sc_pkg::PAD_CHAR;

    // first character sits in the top byte
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int MAX_PRINTED = 60;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_message;
        logic       bad_symbol;
    } t_codec_result;

    t_codec_result expected_out_q[$];

    // predicted codec state
    logic        dir_decode;
    logic [23:0] grp_bits;
    logic [1:0]  grp_fill;
    logic        pad_seen;
    logic        err_seen;

    int fail_total;
    int results_total;

    function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
        return B64_ALPHABET[8 * (63 - int'(s)) +: 8];
    endfunction

    // 7'h40 marks a character outside the alphabet
    function automatic logic [6:0] sextet_of_char(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        for (int i = 0; i < 64; i++) begin
            if (B64_ALPHABET[8 * (63 - i) +: 8] == c) r = 7'(i);
        end
        return r;
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_fill = '0;
        pad_seen = 1'b0;
        err_seen = 1'b0;
    endtask

    task automatic push_expected(input logic [7:0] b);
        t_codec_result r;
        r.out_byte        = b;
        r.last_of_message = 1'b0;
        r.bad_symbol      = err_seen;
        expected_out_q.push_back(r);
    endtask

    // four characters from 24 bits, slots from real_n on become padding
    task automatic push_char_group(input logic [23:0] v, input int real_n);
        logic [5:0] s;
        for (int k = 0; k < 4; k++) begin
            s = v[23 - 6 * k -: 6];
            push_expected(k < real_n ? char_of_sextet(s) : PAD_CHAR);
        end
    endtask

    // works out the results caused by one accepted request
    task automatic predict_codec_results(input logic [7:0] b, input logic eom);
        int          size_before;
        logic [6:0]  sx;
        t_codec_result tail;
        size_before = expected_out_q.size();
        if (!dir_decode) begin
            grp_bits = {grp_bits[15:0], b};
            grp_fill = grp_fill + 2'd1;
            if (grp_fill == 2'd3) begin
                push_char_group(grp_bits, 4);
                grp_bits = '0;
                grp_fill = '0;
            end else if (eom && grp_fill == 2'd1) begin
                push_char_group({grp_bits[7:0], 16'h0}, 2);
            end else if (eom && grp_fill == 2'd2) begin
                push_char_group({grp_bits[15:0], 8'h0}, 3);
            end
        end else begin
            // everything after the first pad character is dropped
            if (!pad_seen) begin
                if (b == PAD_CHAR) begin
                    pad_seen = 1'b1;
                end else begin
                    sx = sextet_of_char(b);
                    if (sx[6]) begin
                        err_seen = 1'b1;
                        sx = '0;
                    end
                    grp_bits = {grp_bits[17:0], sx[5:0]};
                    grp_fill = grp_fill + 2'd1;
                    if (grp_fill == 2'd0) begin
                        push_expected(grp_bits[23:16]);
                        push_expected(grp_bits[15:8]);
                        push_expected(grp_bits[7:0]);
                        grp_bits = '0;
                    end
                end
            end
            // short tail at end of message, lone character gives nothing
            if (eom && expected_out_q.size() == size_before) begin
                if (grp_fill == 2'd2) begin
                    push_expected(grp_bits[11:4]);
                end else if (grp_fill == 2'd3) begin
                    push_expected(grp_bits[17:10]);
                    push_expected(grp_bits[9:2]);
                end
            end
        end
        if (eom) begin
            if (expected_out_q.size() > size_before) begin
                tail = expected_out_q.pop_back();
                tail.last_of_message = 1'b1;
                expected_out_q.push_back(tail);
            end
            clear_group();
        end
    endtask

    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic compare_result();
        t_codec_result exp_r;
        results_total++;
        if (expected_out_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h",
                                      i_out_mon.out_byte));
        end else begin
            exp_r = expected_out_q.pop_front();
            if (i_out_mon.out_byte !== exp_r.out_byte)
                report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                    results_total, i_out_mon.out_byte, exp_r.out_byte));
            if (i_out_mon.last_of_message !== exp_r.last_of_message)
                report_mismatch($sformatf("result %0d last_of_message %b, want %b",
                    results_total, i_out_mon.last_of_message, exp_r.last_of_message));
            if (i_out_mon.bad_symbol !== exp_r.bad_symbol)
                report_mismatch($sformatf("result %0d bad_symbol %b, want %b",
                    results_total, i_out_mon.bad_symbol, exp_r.bad_symbol));
        end
    endtask

    initial begin
        fail_total    = 0;
        results_total = 0;
        dir_decode    = 1'b0;
        clear_group();
    end

    // sample all three channels on each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_decode = 1'b0;
            clear_group();
            expected_out_q.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                dir_decode = i_cfg_mon.direction;
                clear_group();
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_codec_results(i_in_mon.data_byte, i_in_mon.end_of_message);
            if (i_out_mon.valid && i_out_mon.ready)
                compare_result();
        end
        o_fail_count   <= fail_total;
        o_pending      <= expected_out_q.size();
        o_results_seen <= results_total;
    end

endmodule

// File: tb/base64_stream_codec_unit_test.sv
`timescale 1ns / 100ps

module base64_stream_codec_unit_test;
    import b64sc_pkg::PAD_CHAR;

    localparam int CYCLE_LIMIT    = 250000;
    localparam int RANDOM_ITEMS   = 220;
    localparam int PHASE_ITEMS    = 30;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_GAP        = 18;

    logic i_clk;
    logic i_rst_n;

    b64sc_in_if  in_ch();
    b64sc_cfg_if cfg_ch();
    b64sc_out_if out_ch();

    base64_stream_codec_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    int chk_fail;
    int chk_pending;
    int chk_results;

    b64sc_stream_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_cfg_mon      (cfg_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (chk_fail),
        .o_pending      (chk_pending),
        .o_results_seen (chk_results)
    );

    bit         in_idle_on;
    bit         out_idle_on;
    bit         rx_hold_req;
    int         items_sent;
    int         messages_sent;
    int         dir_writes;
    int         cycle_count;
    logic [7:0] msg_buf[$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run limit of %0d cycles reached, %0d results still due",
                 CYCLE_LIMIT, chk_pending);
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                stall = 0;
            end else begin
                stall = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // one request; valid stays high when the next one follows at once
    task automatic send_item(input logic [7:0] b, input logic eom);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_message(input bit with_eom);
        foreach (msg_buf[i])
            send_item(msg_buf[i], with_eom && (i == msg_buf.size() - 1));
        messages_sent++;
    endtask

    task automatic load_text(input string s);
        msg_buf.delete();
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endtask

    // let all results drain, then allow for requests that give none
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic d);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.direction <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        dir_writes++;
    endtask

    function automatic logic [7:0] random_b64_char();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0:       c = 8'h41 + 8'($urandom_range(0, 25));
            1:       c = 8'h61 + 8'($urandom_range(0, 25));
            2:       c = 8'h30 + 8'($urandom_range(0, 9));
            3:       c = 8'h2B;
            default: c = 8'h2F;
        endcase
        return c;
    endfunction

    task automatic build_encode_message();
        int len;
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(12, 24)
                                            : $urandom_range(1, 10);
        msg_buf.delete();
        repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed text with random content, some noise and broken input
    task automatic build_decode_message();
        int kind;
        int nch;
        msg_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            nch = $urandom_range(1, 12);
            repeat (nch) msg_buf.push_back(random_b64_char());
            if (kind == 7)
                msg_buf[$urandom_range(0, nch - 1)] = 8'($urandom_range(0, 255));
            if (kind == 8) begin
                msg_buf.push_back(PAD_CHAR);
                repeat ($urandom_range(1, 5)) msg_buf.push_back(8'($urandom_range(0, 255)));
            end else if (nch % 4 == 2 && $urandom_range(0, 3) != 0) begin
                msg_buf.push_back(PAD_CHAR);
                msg_buf.push_back(PAD_CHAR);
            end else if (nch % 4 == 3 && $urandom_range(0, 3) != 0) begin
                msg_buf.push_back(PAD_CHAR);
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int  phase;
        int  phase_start;
        bit  pressure;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.end_of_message <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.direction     <= 1'b0;
        i_rst_n              <= 1'b0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        rx_hold_req = 1'b0;
        items_sent    = 0;
        messages_sent = 0;
        dir_writes    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: one-byte and two-byte padded tails, full group of extremes
        write_direction(1'b0);
        msg_buf = {8'hFF};
        send_message(1'b1);
        msg_buf = {8'h00, 8'h01};
        send_message(1'b1);
        msg_buf = {8'hFB, 8'hFF, 8'hBF};
        send_message(1'b1);
        wait_idle();

        // decode: padded tails, bad symbol, data after pad, lone character
        write_direction(1'b1);
        load_text("/w==");
        send_message(1'b1);
        load_text("AAE=");
        send_message(1'b1);
        load_text("A*BC");
        send_message(1'b1);
        load_text("Q=#x");
        send_message(1'b1);
        load_text("Z");
        send_message(1'b1);
        wait_idle();

        // random phases alternating direction; phase 2 stalls the result side
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pressure = (phase == 2);
            write_direction(phase[0]);
            phase_start = items_sent;
            if (pressure) rx_hold_req = 1'b1;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                in_idle_on  = !pressure && ($urandom_range(0, 3) != 0);
                out_idle_on = $urandom_range(0, 3) != 0;
                if (phase[0]) build_decode_message();
                else          build_encode_message();
                send_message($urandom_range(0, 9) != 0);
            end
            wait_idle();
            phase++;
        end

        $display("covered %0d requests in %0d messages, %0d direction writes",
                 items_sent, messages_sent, dir_writes);
        $display("%0d results compared, %0d mismatches", chk_results, chk_fail);
        if (chk_fail == 0 && chk_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: base64_stream_codec_unit.f
+incdir+rtl
rtl/b64sc_pkg.sv
rtl/b64sc_ifs.sv
rtl/b64sc_front.sv
rtl/b64sc_queue.sv
rtl/b64sc_back.sv
rtl/base64_stream_codec_unit.sv
tb/b64sc_stream_checker.sv
tb/base64_stream_codec_unit_test.sv
